[src/jmbg_pkg.sv]
// Shared types, codes and small helper functions for the citizen number registry.
`timescale 1ns / 1ps
package jmbg_pkg;

  localparam int NUM_W   = 44;
  localparam int NDIGITS = 14;
  localparam int BCD_W   = 4 * NDIGITS;
  localparam int YEAR_W  = 14;

  localparam logic [1:0] MODE_CHECK    = 2'd0;
  localparam logic [1:0] MODE_GENERATE = 2'd1;
  localparam logic [1:0] MODE_RELEASE  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_NUMBER = 3'd1;
  localparam logic [2:0] ST_DUPLICATE  = 3'd2;
  localparam logic [2:0] ST_BAD_DATA   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd6;

  localparam logic [0:0] CFG_MIN_YEAR = 1'b0;
  localparam logic [0:0] CFG_MAX_YEAR = 1'b1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1917;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2017;

  typedef logic [12:0][3:0] digits_t;
  typedef logic [11:0][3:0] payload_digits_t;

  // check digit weights, most significant digit first
  function automatic logic [3:0] weight(input logic [3:0] i);
    logic [3:0] w;
    case (i)
      4'd0, 4'd6:  w = 4'd7;
      4'd1, 4'd7:  w = 4'd6;
      4'd2, 4'd8:  w = 4'd5;
      4'd3, 4'd9:  w = 4'd4;
      4'd4, 4'd10: w = 4'd3;
      4'd5, 4'd11: w = 4'd2;
      default:     w = 4'd0;
    endcase
    return w;
  endfunction

  // reduce a value below 77 modulo 11
  function automatic logic [3:0] red11(input logic [6:0] x);
    logic [6:0] v;
    v = x;
    for (int j = 0; j < 6; j++) begin
      if (v >= 7'd11) v = v - 7'd11;
    end
    return v[3:0];
  endfunction

  // tens and ones of a value below 100
  function automatic logic [7:0] split10(input logic [6:0] x);
    logic [3:0] q;
    logic [6:0] r;
    q = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (x >= 7'(10 * j)) q = q + 4'd1;
    end
    r = x - 7'(q) * 7'd10;
    return {q, r[3:0]};
  endfunction

  // leap year from decimal digits: th hu te on, where th*10+hu = year/100 mod 4 class
  function automatic logic leap(input logic [3:0] th, input logic [3:0] hu,
                                input logic [3:0] te, input logic [3:0] on);
    logic [5:0] lo;
    logic [5:0] hi;
    lo = 6'({te, 1'b0}) + 6'(on);
    hi = 6'({th, 1'b0}) + 6'(hu);
    if (te == 4'd0 && on == 4'd0) return hi[1:0] == 2'd0;
    return lo[1:0] == 2'd0;
  endfunction

  function automatic logic date_ok(input logic [6:0] d, input logic [6:0] m, input logic lp);
    logic [4:0] lim;
    case (m)
      7'd2:                    lim = lp ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: lim = 5'd30;
      default:                 lim = 5'd31;
    endcase
    return d != 7'd0 && m != 7'd0 && m <= 7'd12 && d <= 7'(lim);
  endfunction

endpackage

[src/jmbg_b2d.sv]
// Serial binary to BCD converter, one input bit per cycle (shift and add-3).
`timescale 1ns / 1ps
module jmbg_b2d (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [jmbg_pkg::NUM_W-1:0]   value,
  output logic                         done,
  output logic [jmbg_pkg::BCD_W-1:0]   bcd
);

  logic [jmbg_pkg::NUM_W-1:0] sh;
  logic [5:0]                 cnt;
  logic                       busy;
  logic [jmbg_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int j = 0; j < jmbg_pkg::NDIGITS; j++) begin
      adj[4*j +: 4] = (bcd[4*j +: 4] >= 4'd5) ? bcd[4*j +: 4] + 4'd3 : bcd[4*j +: 4];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      sh   <= value;
      bcd  <= '0;
    end else if (busy) begin
      bcd <= {adj[jmbg_pkg::BCD_W-2:0], sh[jmbg_pkg::NUM_W-1]};
      sh  <= {sh[jmbg_pkg::NUM_W-2:0], 1'b0};
      cnt <= cnt + 6'd1;
      if (cnt == 6'(jmbg_pkg::NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

[src/jmbg_mod11.sv]
// Weighted mod-11 check digit, one digit per cycle over twelve digits.
`timescale 1ns / 1ps
module jmbg_mod11 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  jmbg_pkg::payload_digits_t        dg,
  output logic                             done,
  output logic [3:0]                       chk
);

  logic [3:0] s;
  logic [3:0] i;
  logic       busy;
  logic [6:0] sum;

  assign sum = 7'(s) + 7'(jmbg_pkg::weight(i)) * 7'(dg[i]);
  // 11 - s, with a zero remainder giving 0
  assign chk = (s == 4'd0) ? 4'd0 : 4'd11 - s;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
      s    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= '0;
      s    <= '0;
    end else if (busy) begin
      s <= jmbg_pkg::red11(sum);
      i <= i + 4'd1;
      if (i == 4'd11) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

[src/jmbg_validate_generate_registry_unit.sv]
// Citizen number registry: check, generate and release numbers under a sequencer.
// Usage:
//   Input channel (in_valid / in_stall) carries one request: mode, citizen_number
//   and the generate fields. Output channel (out_valid / out_stall) returns one
//   result per request: status, number and decoded fields.
//   cfg_write with cfg_index 0 or 1 sets the lowest / highest accepted birth year.
// Timing:
//   in_stall is high from acceptance until the result is moved to the output
//   register; one request is worked on at a time, so latency sets throughput.
//   Check: BCD conversion, evaluation, check digit, then a read and a compare
//   per registry entry searched and a last read step to end the search.
//   Generate: conversion, evaluation, then per tried code the check digit, forming
//   the binary number and a read and a compare per entry searched.
//   Release: a read and a compare per entry searched; a hit adds a read and a move.
//   Every request ends by loading the output register once it is free.
// Reset clears the registry count, the year bounds to 1917..2017 and both channels.
// A stalled result stays in the output register; the next request can be
// taken meanwhile and its result waits until the register frees up.
`timescale 1ns / 1ps
module jmbg_validate_generate_registry_unit #(
  parameter int REGISTRY_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [0:0]   cfg_index,
  input  logic [13:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   mode,
  input  logic [43:0]  citizen_number,
  input  logic [4:0]   birth_day,
  input  logic [3:0]   birth_month,
  input  logic [13:0]  birth_year,
  input  logic [6:0]   region_code,
  input  logic         is_female,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   status,
  output logic [43:0]  number_out,
  output logic [4:0]   day_out,
  output logic [3:0]   month_out,
  output logic [13:0]  year_out,
  output logic [6:0]   region_out,
  output logic         female_out
);

  localparam int CW = $clog2(REGISTRY_DEPTH + 1);
  localparam int AW = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CONV = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_BIN  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_LAST = 4'd7;
  localparam logic [3:0] S_MOVE = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state;
  logic [13:0] min_year;
  logic [13:0] max_year;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] cm1;

  logic [1:0]  r_mode;
  logic [4:0]  r_day;
  logic [3:0]  r_month;
  logic [13:0] r_year;
  logic [6:0]  r_region;
  logic        r_female;
  logic [43:0] key;
  logic [43:0] acc;
  logic [43:0] acc_next;
  logic [3:0]  bidx;
  jmbg_pkg::digits_t dg;
  jmbg_pkg::digits_t nd;

  logic [2:0]  res_status;
  logic [43:0] res_num;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic [6:0]  res_region;
  logic        res_female;

  logic        conv_start;
  logic        conv_done;
  logic [jmbg_pkg::BCD_W-1:0] bcd;
  logic        chk_start;
  logic        chk_done;
  logic [3:0]  chk;

  logic [43:0] mem [REGISTRY_DEPTH];
  logic [43:0] rdata;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] waddr;
  logic [43:0] wdata;
  logic        mem_we;
  logic        full;
  logic        store_now;

  // decoded fields, check mode
  logic [6:0]  d0, m0, r0;
  logic [3:0]  thou;
  logic [13:0] y0;
  logic        ok0;
  // generate mode
  logic        ok1;
  logic [7:0]  dsp, msp, rsp;
  logic        k_last;
  logic [3:0]  k0n, k1n, k2n;

  jmbg_b2d u_b2d (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (key),
    .done  (conv_done),
    .bcd   (bcd)
  );

  jmbg_mod11 u_mod11 (
    .clk   (clk),
    .rst   (rst),
    .start (chk_start),
    .dg    (dg[11:0]),
    .done  (chk_done),
    .chk   (chk)
  );

  always_comb begin
    for (int i = 0; i < 13; i++) begin
      nd[i] = bcd[4*(12-i) +: 4];
    end
    d0   = 7'(nd[0]) * 7'd10 + 7'(nd[1]);
    m0   = 7'(nd[2]) * 7'd10 + 7'(nd[3]);
    r0   = 7'(nd[7]) * 7'd10 + 7'(nd[8]);
    thou = (nd[4] == 4'd9) ? 4'd1 : ((nd[4] == 4'd0) ? 4'd2 : 4'd0);
    y0   = 14'(thou) * 14'd1000 + 14'(nd[4]) * 14'd100 + 14'(nd[5]) * 14'd10 + 14'(nd[6]);
    ok0  = bcd[55:52] == 4'd0 && (nd[0] != 4'd0 || nd[1] != 4'd0) &&
           jmbg_pkg::date_ok(d0, m0, jmbg_pkg::leap(thou, nd[4], nd[5], nd[6])) &&
           y0 >= min_year && y0 <= max_year;
    ok1  = r_year != 14'd0 && r_region <= 7'd99 &&
           jmbg_pkg::date_ok(7'(r_day), 7'(r_month),
                             jmbg_pkg::leap(bcd[15:12], bcd[11:8], bcd[7:4], bcd[3:0]));
    dsp  = jmbg_pkg::split10(7'(r_day));
    msp  = jmbg_pkg::split10(7'(r_month));
    rsp  = jmbg_pkg::split10(r_region);
    // code digits kkk live in dg[9..11]
    k_last = dg[9] == 4'd9 && dg[10] == 4'd9 && dg[11] == 4'd9;
    k2n = (dg[11] == 4'd9) ? 4'd0 : dg[11] + 4'd1;
    k1n = (dg[11] == 4'd9) ? ((dg[10] == 4'd9) ? 4'd0 : dg[10] + 4'd1) : dg[10];
    k0n = (dg[11] == 4'd9 && dg[10] == 4'd9) ? dg[9] + 4'd1 : dg[9];
    acc_next = (acc << 3) + (acc << 1) + 44'(dg[bidx]);
  end

  assign in_stall  = state != S_IDLE;
  assign full      = count == CW'(REGISTRY_DEPTH);
  assign cm1       = count - CW'(1);
  assign store_now = state == S_RD && idx == count &&
                     ((r_mode == jmbg_pkg::MODE_CHECK && !full) ||
                      r_mode == jmbg_pkg::MODE_GENERATE);
  assign mem_we    = store_now || state == S_MOVE;
  assign waddr     = (state == S_MOVE) ? idx[AW-1:0] : count[AW-1:0];
  assign wdata     = (state == S_MOVE) ? rdata : key;
  assign rd_addr   = (state == S_LAST) ? cm1[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= jmbg_pkg::MIN_YEAR_RST;
      max_year <= jmbg_pkg::MAX_YEAR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        jmbg_pkg::CFG_MIN_YEAR: min_year <= cfg_data;
        jmbg_pkg::CFG_MAX_YEAR: max_year <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    conv_start <= 1'b0;
    chk_start  <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_mode     <= mode;
            r_day      <= birth_day;
            r_month    <= birth_month;
            r_year     <= birth_year;
            r_region   <= region_code;
            r_female   <= is_female;
            res_status <= jmbg_pkg::ST_OK;
            res_num    <= '0;
            res_day    <= '0;
            res_month  <= '0;
            res_year   <= '0;
            res_region <= '0;
            res_female <= 1'b0;
            idx        <= '0;
            key        <= (mode == jmbg_pkg::MODE_GENERATE) ? 44'(birth_year) : citizen_number;
            case (mode)
              jmbg_pkg::MODE_CHECK, jmbg_pkg::MODE_GENERATE: begin
                conv_start <= 1'b1;
                state      <= S_CONV;
              end
              jmbg_pkg::MODE_RELEASE: state <= S_RD;
              default: begin
                res_status <= jmbg_pkg::ST_BAD_DATA;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_CONV: begin
          if (conv_done) state <= S_EVAL;
        end
        S_EVAL: begin
          if (r_mode == jmbg_pkg::MODE_CHECK) begin
            if (!ok0) begin
              res_status <= jmbg_pkg::ST_BAD_NUMBER;
              state      <= S_OUT;
            end else begin
              dg        <= nd;
              chk_start <= 1'b1;
              state     <= S_CHK;
            end
          end else if (!ok1) begin
            res_status <= jmbg_pkg::ST_BAD_DATA;
            state      <= S_OUT;
          end else if (full) begin
            res_status <= jmbg_pkg::ST_FULL;
            state      <= S_OUT;
          end else begin
            dg[0]     <= dsp[7:4];
            dg[1]     <= dsp[3:0];
            dg[2]     <= msp[7:4];
            dg[3]     <= msp[3:0];
            dg[4]     <= bcd[11:8];
            dg[5]     <= bcd[7:4];
            dg[6]     <= bcd[3:0];
            dg[7]     <= rsp[7:4];
            dg[8]     <= rsp[3:0];
            dg[9]     <= r_female ? 4'd5 : 4'd0;
            dg[10]    <= 4'd0;
            dg[11]    <= 4'd0;
            dg[12]    <= 4'd0;
            chk_start <= 1'b1;
            state     <= S_CHK;
          end
        end
        S_CHK: begin
          if (chk_done) begin
            if (r_mode == jmbg_pkg::MODE_CHECK) begin
              if (chk == dg[12]) begin
                state <= S_RD;
              end else begin
                res_status <= jmbg_pkg::ST_BAD_NUMBER;
                state      <= S_OUT;
              end
            end else if (chk == 4'd10) begin
              if (k_last) begin
                res_status <= jmbg_pkg::ST_EXHAUSTED;
                state      <= S_OUT;
              end else begin
                dg[9]     <= k0n;
                dg[10]    <= k1n;
                dg[11]    <= k2n;
                chk_start <= 1'b1;
              end
            end else begin
              dg[12] <= chk;
              acc    <= '0;
              bidx   <= '0;
              state  <= S_BIN;
            end
          end
        end
        S_BIN: begin
          acc  <= acc_next;
          bidx <= bidx + 4'd1;
          if (bidx == 4'd12) begin
            key   <= acc_next;
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (idx == count) begin
            state <= S_OUT;
            case (r_mode)
              jmbg_pkg::MODE_CHECK: begin
                if (full) begin
                  res_status <= jmbg_pkg::ST_FULL;
                end else begin
                  count      <= count + CW'(1);
                  res_num    <= key;
                  res_day    <= d0[4:0];
                  res_month  <= m0[3:0];
                  res_year   <= y0;
                  res_region <= r0;
                  res_female <= dg[9] >= 4'd5;
                end
              end
              jmbg_pkg::MODE_GENERATE: begin
                count   <= count + CW'(1);
                res_num <= key;
              end
              default: res_status <= jmbg_pkg::ST_NOT_FOUND;
            endcase
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata == key) begin
            case (r_mode)
              jmbg_pkg::MODE_CHECK: begin
                res_status <= jmbg_pkg::ST_DUPLICATE;
                state      <= S_OUT;
              end
              jmbg_pkg::MODE_GENERATE: begin
                if (k_last) begin
                  res_status <= jmbg_pkg::ST_EXHAUSTED;
                  state      <= S_OUT;
                end else begin
                  dg[9]     <= k0n;
                  dg[10]    <= k1n;
                  dg[11]    <= k2n;
                  chk_start <= 1'b1;
                  state     <= S_CHK;
                end
              end
              default: state <= S_LAST;
            endcase
          end else begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end
        end
        S_LAST: state <= S_MOVE;
        S_MOVE: begin
          // last entry overwrites the released one
          count   <= cm1;
          res_num <= key;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            number_out <= res_num;
            day_out    <= res_day;
            month_out  <= res_month;
            year_out   <= res_year;
            region_out <= res_region;
            female_out <= res_female;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(REGISTRY_DEPTH))
    else $error("registry count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted but block not busy");

  a_move_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (count != '0))
    else $error("release from empty registry");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    store_now |-> !full)
    else $error("store into full registry");
`endif

endmodule

[verif/tb_jmbg_validate_generate_registry_unit.sv]
// Self-checking testbench for the citizen number registry: check, generate and release.
`timescale 1ns / 1ps
module tb_jmbg_validate_generate_registry_unit;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 50000000;
  localparam longint unsigned P11 = 64'd100000000000;
  localparam longint unsigned P9 = 64'd1000000000;
  localparam longint unsigned P6 = 64'd1000000;
  localparam longint unsigned P4 = 64'd10000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  st;
    logic [43:0] num;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  region;
    logic        female;
  } reg_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = jmbg_pkg::CFG_MIN_YEAR;
  logic [13:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = jmbg_pkg::MODE_CHECK;
  logic [43:0] citizen_number = '0;
  logic [4:0] birth_day = '0;
  logic [3:0] birth_month = '0;
  logic [13:0] birth_year = '0;
  logic [6:0] region_code = '0;
  logic is_female = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [43:0] number_out;
  logic [4:0] day_out;
  logic [3:0] month_out;
  logic [13:0] year_out;
  logic [6:0] region_out;
  logic female_out;

  jmbg_validate_generate_registry_unit #(.REGISTRY_DEPTH(DEPTH)) uut (.*);

  // predictor state
  int unsigned year_lo = 1917, year_hi = 2017;
  longint unsigned issued[$];
  reg_result_t pending_results[$];

  int errors = 0;
  int unsigned cycles = 0;
  int sender_idle_pct = 0, receiver_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = 3000;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    reg_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (number_out !== e.num) report_mismatch("number_out", number_out, e.num);
        if (day_out !== e.day) report_mismatch("day_out", day_out, e.day);
        if (month_out !== e.month) report_mismatch("month_out", month_out, e.month);
        if (year_out !== e.year) report_mismatch("year_out", year_out, e.year);
        if (region_out !== e.region) report_mismatch("region_out", region_out, e.region);
        if (female_out !== e.female) report_mismatch("female_out", female_out, e.female);
      end
    end
  end

  function automatic void to_digits(input longint unsigned n, output int dg[13]);
    for (int i = 12; i >= 0; i--) begin
      dg[i] = int'(n % 10);
      n = n / 10;
    end
  endfunction

  function automatic int mod11_digit(input int dg[13]);
    int w[12] = '{7, 6, 5, 4, 3, 2, 7, 6, 5, 4, 3, 2};
    int s = 0;
    int c;
    for (int i = 0; i < 12; i++) s += w[i] * dg[i];
    c = 11 - s % 11;
    return (c == 11) ? 0 : c;
  endfunction

  function automatic bit good_date(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
    int unsigned lim;
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (y < 1 || d < 1 || m < 1 || m > 12) return 0;
    lim = mdays[m - 1];
    if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) lim++;
    return d <= lim;
  endfunction

  function automatic int find_issued(input longint unsigned n);
    foreach (issued[i]) if (issued[i] == n) return i;
    return -1;
  endfunction

  // citizen number with a correct check digit (10 leaves the digit at 0)
  function automatic longint unsigned make_number(input int d, input int m, input int y3,
                                                  input int r, input int k);
    longint unsigned base;
    int dg[13];
    int c;
    base = longint'(d) * P11 + longint'(m) * P9 + longint'(y3) * P6 + longint'(r) * P4
           + longint'(k) * 10;
    to_digits(base, dg);
    c = mod11_digit(dg);
    return (c == 10) ? base : base + c;
  endfunction

  function automatic reg_result_t registry_outcome(input logic [1:0] md, input logic [43:0] n,
      input logic [4:0] bd, input logic [3:0] bm, input logic [13:0] by, input logic [6:0] rc,
      input logic fem);
    reg_result_t res;
    int dg[13];
    int unsigned d, m, y, r, k;
    longint unsigned base, cand;
    int c, pos;
    res = '{jmbg_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b0};
    case (md)
      jmbg_pkg::MODE_CHECK: begin
        if (n < P11 || n > 64'd9999999999999) begin
          res.st = jmbg_pkg::ST_BAD_NUMBER;
          return res;
        end
        to_digits(n, dg);
        d = dg[0] * 10 + dg[1];
        m = dg[2] * 10 + dg[3];
        y = dg[4] * 100 + dg[5] * 10 + dg[6];
        if (dg[4] == 9) y += 1000;
        else if (dg[4] == 0) y += 2000;
        r = dg[7] * 10 + dg[8];
        k = dg[9] * 100 + dg[10] * 10 + dg[11];
        if (!good_date(d, m, y) || mod11_digit(dg) != dg[12] || y < year_lo || y > year_hi)
          res.st = jmbg_pkg::ST_BAD_NUMBER;
        else if (find_issued(n) >= 0) res.st = jmbg_pkg::ST_DUPLICATE;
        else if (issued.size() >= DEPTH) res.st = jmbg_pkg::ST_FULL;
        else begin
          issued.push_back(n);
          res.num = n;
          res.day = 5'(d);
          res.month = 4'(m);
          res.year = 14'(y);
          res.region = 7'(r);
          res.female = (k > 499);
        end
      end
      jmbg_pkg::MODE_GENERATE: begin
        if (!good_date(bd, bm, by) || rc > 99) res.st = jmbg_pkg::ST_BAD_DATA;
        else if (issued.size() >= DEPTH) res.st = jmbg_pkg::ST_FULL;
        else begin
          res.st = jmbg_pkg::ST_EXHAUSTED;
          base = longint'(bd) * P11 + longint'(bm) * P9 + longint'(by % 1000) * P6
                 + longint'(rc) * P4;
          for (k = fem ? 500 : 0; k <= 999; k++) begin
            cand = base + longint'(k) * 10;
            to_digits(cand, dg);
            c = mod11_digit(dg);
            if (c != 10 && find_issued(cand + c) < 0) begin
              issued.push_back(cand + c);
              res.st = jmbg_pkg::ST_OK;
              res.num = 44'(cand + c);
              break;
            end
          end
        end
      end
      jmbg_pkg::MODE_RELEASE: begin
        pos = find_issued(n);
        if (pos < 0) res.st = jmbg_pkg::ST_NOT_FOUND;
        else begin
          issued[pos] = issued[issued.size() - 1];
          void'(issued.pop_back());
          res.num = n;
        end
      end
      default: res.st = jmbg_pkg::ST_BAD_DATA;
    endcase
    return res;
  endfunction

  // one transaction; valid stays high afterwards until the next gap or drain
  task automatic send_item(input logic [1:0] md, input logic [43:0] n, input logic [4:0] bd,
      input logic [3:0] bm, input logic [13:0] by, input logic [6:0] rc, input logic fem);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    citizen_number <= n;
    birth_day <= bd;
    birth_month <= bm;
    birth_year <= by;
    region_code <= rc;
    is_female <= fem;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(registry_outcome(md, n, bd, bm, by, rc, fem));
  endtask

  task automatic send_check(input longint unsigned n);
    send_item(jmbg_pkg::MODE_CHECK, 44'(n), 5'($urandom), 4'($urandom), 14'($urandom),
              7'($urandom), 1'($urandom));
  endtask

  task automatic send_release(input longint unsigned n);
    send_item(jmbg_pkg::MODE_RELEASE, 44'(n), 5'($urandom), 4'($urandom), 14'($urandom),
              7'($urandom), 1'($urandom));
  endtask

  task automatic send_generate(input int d, input int m, input int y, input int r,
                               input bit fem);
    send_item(jmbg_pkg::MODE_GENERATE, 44'({$urandom, $urandom}), 5'(d), 4'(m), 14'(y),
              7'(r), fem);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [13:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == jmbg_pkg::CFG_MIN_YEAR) year_lo = val;
    else year_hi = val;
  endtask

  task automatic set_bounds(input int lo, input int hi);
    drain();
    write_cfg(jmbg_pkg::CFG_MIN_YEAR, 14'(lo));
    write_cfg(jmbg_pkg::CFG_MAX_YEAR, 14'(hi));
  endtask

  task automatic test_directed_checks();
    longint unsigned n;
    send_check(0);
    send_check(64'd9999999999999);
    send_check(44'hFFFFFFFFFFF);
    send_check(64'd99999999999);                    // eleven digits
    n = make_number(29, 2, 0, 71, 123);             // leap day of 2000
    send_check(n);
    send_check(n);                                  // duplicate
    send_check(make_number(1, 1, 17, 99, 999));     // twelve digits, upper bound year
    send_check(make_number(31, 12, 917, 0, 500));   // lower bound year, female
    send_check(make_number(1, 1, 916, 10, 1));      // one below lower bound
    send_check(make_number(30, 2, 996, 10, 1));     // bad date
    send_check(make_number(15, 6, 950, 10, 1) ^ 44'd1);
    send_item(MODE_UNUSED, 44'(n), 5'd31, 4'd15, 14'h3FFF, 7'h7F, 1'b1);
  endtask

  task automatic test_generate_release();
    send_generate(1, 1, 1, 0, 0);
    send_generate(31, 12, 9999, 99, 1);
    send_generate(29, 2, 2000, 50, 1);
    send_generate(29, 2, 1900, 50, 0);              // not a leap year
    send_generate(1, 1, 0, 0, 0);                   // year zero
    send_generate(1, 13, 1990, 0, 0);
    send_generate(0, 5, 1990, 0, 0);
    send_generate(1, 5, 1990, 100, 0);
    send_generate(1, 5, 1990, 127, 1);
    send_generate(1, 5, 1990, 7, 0);
    send_generate(1, 5, 1990, 7, 0);                // code steps past the first
    drain();
    send_release(issued[0]);
    send_release(issued[0]);                        // last entry moved into place
    send_release(64'd1234567890123);                // not registered
  endtask

  task automatic test_year_bounds();
    set_bounds(0, 14'h3FFF);
    send_check(make_number(29, 2, 900, 1, 1));      // 1900 is not leap
    send_check(make_number(28, 2, 100, 1, 1));      // plain three-digit year
    send_check(make_number(1, 1, 899, 1, 1));
    set_bounds(9999, 0);                            // inverted bounds
    send_check(make_number(1, 1, 950, 1, 1));
    send_check(make_number(1, 1, 50, 1, 1));
    set_bounds(2000, 2000);
    send_check(make_number(1, 1, 0, 2, 2));
    send_check(make_number(1, 1, 1, 2, 2));
    set_bounds(1917, 2017);
  endtask

  task automatic test_fill_registry();
    while (issued.size() < DEPTH) begin
      send_generate($urandom_range(1, 28), $urandom_range(1, 12), $urandom_range(1, 2099),
                    $urandom_range(0, 99), $urandom);
      drain();
    end
    send_generate(1, 1, 1990, 1, 0);                // full
    send_check(make_number(2, 2, 990, 3, 3));       // full
    send_check(issued[5]);                          // duplicate wins over full
    drain();
    while (issued.size() > 8) send_release(issued[$urandom_range(0, issued.size() - 1)]);
    drain();
  endtask

  task automatic random_item();
    int pick, yr;
    longint unsigned n;
    pick = $urandom_range(99);
    yr = $urandom_range(1900, 2099);
    if (pick < 30) begin
      send_check(make_number($urandom_range(1, 29), $urandom_range(1, 12), yr % 1000,
                             $urandom_range(0, 99), $urandom_range(0, 999)));
    end else if (pick < 38 && issued.size() > 0) begin
      send_check(issued[$urandom_range(0, issued.size() - 1)]);
    end else if (pick < 60) begin
      send_generate($urandom_range(1, 29), $urandom_range(1, 12),
                    ($urandom_range(3) == 0) ? $urandom_range(1, 9999) : yr,
                    $urandom_range(0, 99), $urandom);
    end else if (pick < 88) begin
      if (issued.size() > 0 && $urandom_range(9) < 8)
        send_release(issued[$urandom_range(0, issued.size() - 1)]);
      else
        send_release({$urandom, $urandom});
    end else if (pick < 94) begin
      n = make_number($urandom_range(0, 39), $urandom_range(0, 15), $urandom_range(0, 999),
                      $urandom_range(0, 99), $urandom_range(0, 999));
      send_check(($urandom_range(1)) ? n : n + $urandom_range(1, 9));
    end else begin
      send_item(2'($urandom_range(0, 3)), 44'({$urandom, $urandom}), 5'($urandom),
                4'($urandom), 14'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_request = 1;
    repeat (6) random_item();
    drain();
  endtask

  task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
    sender_idle_pct = snd_pct;
    receiver_idle_pct = rcv_pct;
    repeat (count) random_item();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_checks();
    test_generate_release();
    test_year_bounds();
    test_fill_registry();
    test_backpressure();
    test_random(480, 27, 86);
    set_bounds(0, 9999);
    test_random(480, 86, 27);
    set_bounds(1950, 2050);
    test_random(480, 0, 0);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/jmbg_pkg.sv
src/jmbg_b2d.sv
src/jmbg_mod11.sv
src/jmbg_validate_generate_registry_unit.sv
verif/tb_jmbg_validate_generate_registry_unit.sv
